// ----- src/fxa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, status codes, shared types and the saturation helper.
// ----------------------------------------------------------------------------
package fxa_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_EQ      = 4'd4,
		OP_NE      = 4'd5,
		OP_GT      = 4'd6,
		OP_LT      = 4'd7,
		OP_GE      = 4'd8,
		OP_LE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Result that rides alongside the divider pipeline.
	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              cmp;
		status_t           status;
		logic              is_div;
		logic              neg;
		logic              div_zero;
		logic              div_ovf;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} sat_t;

	// Applies a sign to a magnitude and clamps to the signed 32-bit range.
	function automatic sat_t sat_mag(input logic [63:0] mag, input logic neg);
		sat_t r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) begin
				r.val = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				r.val = 32'(64'd0 - mag);
				r.sat = 1'b0;
			end
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) begin
				r.val = 32'h7FFF_FFFF;
				r.sat = 1'b1;
			end else begin
				r.val = mag[31:0];
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ----- src/fxa_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, 32 stages, advancing together on en.
// ----------------------------------------------------------------------------
module fxa_div_pipe (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] rem_in,
	input  logic [31:0] low_in,
	input  logic [31:0] den_in,
	output logic [31:0] quo,
	output logic [31:0] rem,
	output logic [31:0] den
);
	localparam int STEPS = 32;

	logic [31:0] rem_s [0:STEPS];
	logic [31:0] low_s [0:STEPS];
	logic [31:0] quo_s [0:STEPS];
	logic [31:0] den_s [0:STEPS];

	assign rem_s[0] = rem_in;
	assign low_s[0] = low_in;
	assign quo_s[0] = '0;
	assign den_s[0] = den_in;

	// Each stage brings down one dividend bit and tries one subtraction.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		assign trial = {rem_s[k], low_s[k][31]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[32]) begin
					rem_s[k+1] <= diff[31:0];
					quo_s[k+1] <= {quo_s[k][30:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[31:0];
					quo_s[k+1] <= {quo_s[k][30:0], 1'b0};
				end
				low_s[k+1] <= {low_s[k][30:0], 1'b0};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quo = quo_s[STEPS];
	assign rem = rem_s[STEPS];
	assign den = den_s[STEPS];

endmodule

// ----- src/fixed_point_q24_8_alu.sv -----
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Add, subtract, multiply, divide, compare and convert on signed raw values,
// with rounding to nearest (ties away from zero) for multiply and divide, and saturation.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: operand_a, operand_b; tuser: operation
//  m_*      | out       | tdata: value; tuser: compare_true, status
//
// One request enters per cycle while the pipeline is not stalled; each result
// passes through stage 1, stage 2, the 32-stage divider pipeline that every
// operation passes through in lockstep, and the output register. The whole
// pipeline advances when the output register is empty or being taken, so a
// stall holds every stage. Reset clears only the valid bits.
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [3:0]  s_tuser,   // [3:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [2:0]  m_tuser    // [0] compare_true, [2:1] status
);
	import fxa_pkg::*;

	localparam int DIV_STEPS = 32;
	localparam int LAST      = DIV_STEPS + 3;

	logic en;
	logic vld_q [1:LAST];

	assign en       = !vld_q[LAST] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAST];

	// Valid bits travel with the requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= s_tvalid;
			for (int i = 2; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// Stage 1: capture operands and their magnitudes.
	op_t         op_s1;
	logic [31:0] a_s1, b_s1, abs_a_s1, abs_b_s1;
	logic        neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op_t'(s_tuser);
			a_s1     <= s_tdata[31:0];
			b_s1     <= s_tdata[63:32];
			abs_a_s1 <= s_tdata[31] ? 32'd0 - s_tdata[31:0] : s_tdata[31:0];
			abs_b_s1 <= s_tdata[63] ? 32'd0 - s_tdata[63:32] : s_tdata[63:32];
			neg_s1   <= s_tdata[31] ^ s_tdata[63];
		end
	end

	// Stage 2 logic: simple operations, divider setup.
	side_t       simple;
	logic [32:0] sum, dif, incv, decv;
	logic        lt, eq;
	logic [FRAC_BITS:0] top_bits;
	logic [31:0] hi_part;

	always_comb begin
		sum  = {a_s1[31], a_s1} + {b_s1[31], b_s1};
		dif  = {a_s1[31], a_s1} - {b_s1[31], b_s1};
		incv = {a_s1[31], a_s1} + 33'd1;
		decv = {a_s1[31], a_s1} - 33'd1;
		lt   = $signed(a_s1) < $signed(b_s1);
		eq   = a_s1 == b_s1;
		top_bits = a_s1[31:31-FRAC_BITS];
		hi_part  = 32'(abs_a_s1 >> (32 - FRAC_BITS));

		simple          = '0;
		simple.status   = ST_OK;
		simple.is_div   = op_s1 == OP_DIV;
		simple.neg      = neg_s1;
		simple.div_zero = b_s1 == 32'd0;
		simple.div_ovf  = hi_part >= abs_b_s1;
		case (op_s1)
			OP_ADD: begin
				if (sum[32] != sum[31]) begin
					simple.val    = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					simple.status = ST_OVERFLOW;
				end else simple.val = sum[31:0];
			end
			OP_SUB: begin
				if (dif[32] != dif[31]) begin
					simple.val    = dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					simple.status = ST_OVERFLOW;
				end else simple.val = dif[31:0];
			end
			OP_INC: begin
				if (incv[32] != incv[31]) begin
					simple.val    = 32'h7FFF_FFFF;
					simple.status = ST_OVERFLOW;
				end else simple.val = incv[31:0];
			end
			OP_DEC: begin
				if (decv[32] != decv[31]) begin
					simple.val    = 32'h8000_0000;
					simple.status = ST_OVERFLOW;
				end else simple.val = decv[31:0];
			end
			OP_EQ:    simple.cmp = eq;
			OP_NE:    simple.cmp = !eq;
			OP_GT:    simple.cmp = !lt && !eq;
			OP_LT:    simple.cmp = lt;
			OP_GE:    simple.cmp = !lt;
			OP_LE:    simple.cmp = lt || eq;
			OP_MIN:   simple.val = (lt || eq) ? a_s1 : b_s1;
			OP_MAX:   simple.val = !lt ? a_s1 : b_s1;
			OP_TOINT: simple.val = 32'($signed(a_s1) >>> FRAC_BITS);
			OP_FROMINT: begin
				if (top_bits != '0 && top_bits != '1) begin
					simple.val    = a_s1[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					simple.status = ST_OVERFLOW;
				end else simple.val = a_s1 << FRAC_BITS;
			end
			default: ;
		endcase
	end

	// Stage 2: product, simple result, divider operands.
	side_t       side_s2;
	logic        is_mul_s2;
	logic [63:0] prod_s2;
	logic [31:0] div_rem_s2, div_low_s2, div_den_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2    <= simple;
			is_mul_s2  <= op_s1 == OP_MUL;
			prod_s2    <= {32'd0, abs_a_s1} * {32'd0, abs_b_s1};
			div_rem_s2 <= simple.div_ovf ? 32'd0 : hi_part;
			div_low_s2 <= abs_a_s1 << FRAC_BITS;
			div_den_s2 <= abs_b_s1;
		end
	end

	// Stage 3 logic: round and clamp the product.
	logic [63:0] mul_mag;
	sat_t        mul_res;
	side_t       side_in3;

	always_comb begin
		mul_mag  = (prod_s2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		mul_res  = sat_mag(mul_mag, side_s2.neg);
		side_in3 = side_s2;
		if (is_mul_s2) begin
			side_in3.val    = mul_res.val;
			side_in3.status = mul_res.sat ? ST_OVERFLOW : ST_OK;
		end
	end

	// Side results delayed to meet the divider output.
	side_t side_s [3:LAST-1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[3] <= side_in3;
			for (int i = 4; i <= LAST - 1; i++) side_s[i] <= side_s[i-1];
		end
	end

	logic [31:0] quo, rem, den;

	fxa_div_pipe u_div (
		.clk    (clk),
		.en     (en),
		.rem_in (div_rem_s2),
		.low_in (div_low_s2),
		.den_in (div_den_s2),
		.quo    (quo),
		.rem    (rem),
		.den    (den)
	);

	// Final stage logic: round the quotient and merge.
	side_t       fin;
	logic        rnd;
	logic [63:0] div_mag;
	sat_t        div_res;

	always_comb begin
		fin     = side_s[LAST-1];
		rnd     = {rem, 1'b0} >= {1'b0, den};
		div_mag = {32'd0, quo} + {63'd0, rnd};
		div_res = sat_mag(div_mag, fin.neg);
		if (fin.is_div) begin
			if (fin.div_zero) begin
				fin.val    = '0;
				fin.status = ST_DIV_ZERO;
			end else if (fin.div_ovf) begin
				fin.val    = fin.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				fin.status = ST_OVERFLOW;
			end else begin
				fin.val    = div_res.val;
				fin.status = div_res.sat ? ST_OVERFLOW : ST_OK;
			end
		end
	end

	// Output register.
	logic [31:0] val_s35;
	logic [2:0]  user_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			val_s35  <= fin.val;
			user_s35 <= {fin.status, fin.cmp};
		end
	end

	assign m_tdata = val_s35;
	assign m_tuser = user_s35;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU testbench
// Drives operation requests with random gaps and random output stalls,
// predicts each result with an exact integer model and checks every field.
// ----------------------------------------------------------------------------
module tb;
	import fxa_pkg::*;

	localparam int FRAC = 8;
	localparam int NUM_RANDOM = 1430;
	localparam int LIMIT = 400000;
	localparam longint RAW_HI = 64'sd2147483647;
	localparam longint RAW_LO = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		status_t     status;
	} alu_result_t;

	// Holds predicted results in request order and checks arrivals.
	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;

		function longint clamp(longint x, inout status_t st);
			if (x > RAW_HI) begin
				st = ST_OVERFLOW;
				return RAW_HI;
			end
			if (x < RAW_LO) begin
				st = ST_OVERFLOW;
				return RAW_LO;
			end
			return x;
		endfunction

		function alu_result_t compute(op_t op, logic signed [31:0] ra,
				logic signed [31:0] rb);
			alu_result_t r;
			longint a;
			longint b;
			longint v;
			longint unsigned ma;
			longint unsigned mb;
			longint unsigned mag;
			logic neg;
			status_t st;
			a = ra;
			b = rb;
			v = 0;
			st = ST_OK;
			r.cmp = 1'b0;
			ma = (a < 0) ? -a : a;
			mb = (b < 0) ? -b : b;
			neg = (a < 0) != (b < 0);
			case (op)
				OP_ADD: v = clamp(a + b, st);
				OP_SUB: v = clamp(a - b, st);
				OP_MUL: begin
					mag = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
					v = clamp(neg ? -longint'(mag) : longint'(mag), st);
				end
				OP_DIV: begin
					if (b == 0) begin
						st = ST_DIV_ZERO;
					end else begin
						mag = (2 * (ma << FRAC) + mb) / (2 * mb);
						v = clamp(neg ? -longint'(mag) : longint'(mag), st);
					end
				end
				OP_EQ: r.cmp = a == b;
				OP_NE: r.cmp = a != b;
				OP_GT: r.cmp = a > b;
				OP_LT: r.cmp = a < b;
				OP_GE: r.cmp = a >= b;
				OP_LE: r.cmp = a <= b;
				OP_MIN: v = (a <= b) ? a : b;
				OP_MAX: v = (a >= b) ? a : b;
				OP_INC: v = clamp(a + 1, st);
				OP_DEC: v = clamp(a - 1, st);
				OP_TOINT: v = a >>> FRAC;
				default: v = clamp(a * (64'sd1 <<< FRAC), st);
			endcase
			r.value = v[31:0];
			r.status = st;
			return r;
		endfunction

		function void note_request(op_t op, logic [31:0] a, logic [31:0] b);
			pending.push_back(compute(op, a, b));
		endfunction

		function void check_result(logic [31:0] value, logic [2:0] user);
			alu_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result value=%h user=%h", $time, value, user);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (value !== e.value) begin
				$display("%0t: value expected %h actual %h", $time, e.value, value);
				errors++;
			end
			if (user[0] !== e.cmp) begin
				$display("%0t: compare expected %b actual %b", $time, e.cmp, user[0]);
				errors++;
			end
			if (user[2:1] !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, user[2:1]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	alu_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	int cycles = 0;

	fixed_point_q24_8_alu dut (.*);

	always #10 clk = ~clk;

	// Sends one request and waits until it is taken; a gap may come first.
	task automatic send_request(op_t op, logic [31:0] a, logic [31:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, a, b);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			3: return 32'($signed($urandom_range(0, 8191)) - 4096);
			4: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
			5: return $urandom() & 32'h00FF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Stimulus: directed corners, then random requests.
	initial begin
		logic [31:0] a;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 16; i++)
			send_request(op_t'(i), 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_DIV, 32'h0000_0300, 32'h0);
		send_request(OP_MUL, 32'h0000_0180, 32'h0000_0001);
		send_request(OP_MUL, 32'hFFFF_FE80, 32'h0000_0001);
		send_request(OP_DIV, 32'h0000_0001, 32'h0000_0200);
		send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
		send_request(OP_TOINT, 32'hFFFF_FF01, 32'h0);
		send_request(OP_FROMINT, 32'h0080_0000, 32'h0);
		send_request(OP_MIN, 32'h5, 32'h5);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM - 150)
				calm = 1'b1;
			if (n == 300)
				hold_off = 1'b1;
			a = pick_operand();
			send_request(op_t'($urandom_range(0, 15)), a,
				$urandom_range(0, 5) == 0 ? a : pick_operand());
		end
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off so the pipeline fills.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (120) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Checks every accepted result.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
	end

	// Guards against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
